FILE: design/hbs_pkg.sv
// Shared constants, types and codes for the heightmap bilinear sampler.
`default_nettype none

package hbs_pkg;

  // Heightmap geometry
  localparam int MAX_DIM     = 256;
  localparam int FRAC_BITS   = 8;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = IDX_W + DIM_W;

  // Port field widths
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int TEXEL_IDX_W = 16;
  localparam int TEXEL_W     = 8;
  localparam int COORD_W     = 19;
  localparam int HEIGHT_W    = 18;
  localparam int OUT_FRAC    = 16;

  // Blend arithmetic
  localparam int ONE_W   = FRAC_BITS + 1;
  localparam int WGT_W   = 2 * FRAC_BITS + 1;
  localparam int PROD_W  = TEXEL_W + WGT_W;
  localparam int SUM_W   = TEXEL_W + 2 * FRAC_BITS;

  // Scaling to 16 fraction bits before the divide by 100
  localparam int DIV_SHL = (OUT_FRAC > 2 * FRAC_BITS) ? OUT_FRAC - 2 * FRAC_BITS : 0;
  localparam int DIV_SHR = (OUT_FRAC > 2 * FRAC_BITS) ? 0 : 2 * FRAC_BITS - OUT_FRAC;
  localparam int NUM_W   = SUM_W + DIV_SHL - DIV_SHR;

  // Reciprocal divide by 100: q = (n * RECIP) >> RECIP_K, then one fix-up step
  localparam int DIVISOR   = 100;
  localparam int DIVISOR_W = 7;
  localparam int RECIP_K   = 32;
  localparam longint unsigned RECIP = (64'd1 << RECIP_K) / 64'(DIVISOR);
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int QUOT_W    = NUM_W + RECIP_W - RECIP_K;

  // Request modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_WAIT,
    ST_DIV,
    ST_DONE
  } hbs_state_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic       setup;  // latch fractions, build weights, clear accumulator
    logic       take;   // read data valid this cycle
    logic [1:0] sel;    // corner of the read data
  } hbs_mac_ctrl_t;

endpackage

`default_nettype wire

FILE: design/hbs_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface hbs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hbs_pkg::CFG_IDX_W-1:0]  index;
  logic [hbs_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/hbs_req_if.sv
// Request channel: texel writes and sample queries.
`default_nettype none

interface hbs_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic [hbs_pkg::TEXEL_IDX_W-1:0]      texel_index;
  logic [hbs_pkg::TEXEL_W-1:0]          texel_value;
  logic signed [hbs_pkg::COORD_W-1:0]   query_x;
  logic signed [hbs_pkg::COORD_W-1:0]   query_z;

  modport source (output valid, output mode, output texel_index, output texel_value,
                  output query_x, output query_z, input ready);
  modport sink   (input valid, input mode, input texel_index, input texel_value,
                  input query_x, input query_z, output ready);
endinterface

`default_nettype wire

FILE: design/hbs_rsp_if.sv
// Response channel: sampled height.
`default_nettype none

interface hbs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [hbs_pkg::HEIGHT_W-1:0]   height;
  logic                           outside;

  modport source (output valid, output height, output outside, input ready);
  modport sink   (input valid, input height, input outside, output ready);
endinterface

`default_nettype wire

FILE: design/hbs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/hbs_mac.sv
// Corner weights and multiply-accumulate of the four texels.
`default_nettype none

module hbs_mac (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hbs_pkg::hbs_mac_ctrl_t         ctrl_i,
  input  wire logic [hbs_pkg::FRAC_BITS-1:0]  fx_i,
  input  wire logic [hbs_pkg::FRAC_BITS-1:0]  fz_i,
  input  wire logic [hbs_pkg::TEXEL_W-1:0]    rdata_i,
  output logic      [hbs_pkg::SUM_W-1:0]      sum_o,
  output logic                                done_o
);

  localparam int ONE_W = hbs_pkg::ONE_W;
  localparam int WGT_W = hbs_pkg::WGT_W;
  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << hbs_pkg::FRAC_BITS;

  logic [ONE_W-1:0]            wxl, wxh, wzl, wzh;
  logic [2*ONE_W-1:0]          w00, w01, w10, w11;
  logic [WGT_W-1:0]            weight_q [4];
  logic [hbs_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic                        prod_vld_q;
  logic [1:0]                  prod_sel_q;
  logic [hbs_pkg::SUM_W-1:0]   acc_d, acc_q;
  logic                        done_d, done_q;

  assign wxh = ONE_W'(fx_i);
  assign wzh = ONE_W'(fz_i);
  assign wxl = ONE - wxh;
  assign wzl = ONE - wzh;
  assign w00 = (2*ONE_W)'(wxl) * (2*ONE_W)'(wzl);
  assign w01 = (2*ONE_W)'(wxh) * (2*ONE_W)'(wzl);
  assign w10 = (2*ONE_W)'(wxl) * (2*ONE_W)'(wzh);
  assign w11 = (2*ONE_W)'(wxh) * (2*ONE_W)'(wzh);

  // weights never exceed ONE*ONE, so the top bit is always clear
  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      weight_q[0] <= w00[WGT_W-1:0];
      weight_q[1] <= w01[WGT_W-1:0];
      weight_q[2] <= w10[WGT_W-1:0];
      weight_q[3] <= w11[WGT_W-1:0];
    end
  end

  assign prod_d = hbs_pkg::PROD_W'(rdata_i) * hbs_pkg::PROD_W'(weight_q[ctrl_i.sel]);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    acc_d  = acc_q;
    done_d = 1'b0;
    if (ctrl_i.setup) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d  = acc_q + prod_q[hbs_pkg::SUM_W-1:0];
      done_d = (prod_sel_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_sel_q <= '0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.take;
      prod_sel_q <= ctrl_i.sel;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign sum_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: design/hbs_div100.sv
// Divide by 100 via reciprocal multiply with one correction step.
`default_nettype none

module hbs_div100 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [hbs_pkg::SUM_W-1:0]     sum_i,
  output logic                               done_o,
  output logic      [hbs_pkg::HEIGHT_W-1:0]  quot_o
);

  localparam int NUM_W  = hbs_pkg::NUM_W;
  localparam int QUOT_W = hbs_pkg::QUOT_W;
  localparam int PMUL_W = NUM_W + hbs_pkg::RECIP_W;
  localparam int Q100_W = QUOT_W + hbs_pkg::DIVISOR_W;
  localparam int WIDE_W = hbs_pkg::SUM_W + hbs_pkg::DIV_SHL;

  logic [WIDE_W-1:0]  num_wide;
  logic [NUM_W-1:0]   num, num_q;
  logic [PMUL_W-1:0]  pmul_q;
  logic               vld1_q, done_q;
  logic [QUOT_W-1:0]  q_est, q_fix;
  logic [Q100_W-1:0]  q100;
  logic [NUM_W-1:0]   rem;
  logic [hbs_pkg::HEIGHT_W-1:0] quot_q;

  // align the blend to 16 fraction bits
  assign num_wide = WIDE_W'(sum_i) << hbs_pkg::DIV_SHL;
  assign num      = NUM_W'(num_wide >> hbs_pkg::DIV_SHR);

  always_ff @(posedge clk_i) begin
    num_q  <= num;
    pmul_q <= PMUL_W'(num) * PMUL_W'(hbs_pkg::RECIP);
  end

  // estimate is low by at most one
  assign q_est = pmul_q[hbs_pkg::RECIP_K +: QUOT_W];
  assign q100  = Q100_W'(q_est) * Q100_W'(hbs_pkg::DIVISOR);
  assign rem   = num_q - NUM_W'(q100);
  assign q_fix = q_est + QUOT_W'(rem >= NUM_W'(hbs_pkg::DIVISOR));

  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      quot_q <= hbs_pkg::HEIGHT_W'(q_fix);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      done_q <= vld1_q;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: design/heightmap_bilinear_sampler_unit.sv
// Top level of the heightmap bilinear sampler: sequencer, config and result register.
`default_nettype none

// Holds a 256 x 256 byte heightmap in one single-port RAM, addressed row-major
// (column + row * grid_width). A write request (mode 0) stores one texel in the
// cycle it is accepted; addresses beyond the store are dropped; no response.
// A sample request (mode 1) carries signed x/z with 8 fraction bits. Points with
// a negative coordinate or one at or past the grid size answer height 0 with
// outside set, via the done state and the result register. Otherwise the four
// neighbours are read one per cycle through the RAM port (the +1 neighbours
// clamped to the last column/row), blended with exact 8-bit fraction weights,
// and divided by 100 into an unsigned value with 16 fraction bits, truncated.
// An in-grid sample occupies the block from acceptance until it can take the
// next request: setup, four RAM reads, multiply-accumulate drain, reciprocal
// divide, and loading the result register once it is free. The result sits in
// its own register, so writes and the next sample are taken while it waits.
// grid_width/grid_height above 256 act as 256; 0 makes every sample outside.
// Texels read by a sample must have been written first; the RAM has no reset.
// Configuration writes are always ready and take effect the next cycle; they
// are only to be issued with no sample in flight.

module heightmap_bilinear_sampler_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbs_cfg_if.sink    cfg_i,
  hbs_req_if.sink    req_i,
  hbs_rsp_if.source  rsp_o
);

  localparam int FRAC_BITS = hbs_pkg::FRAC_BITS;
  localparam int IDX_W     = hbs_pkg::IDX_W;
  localparam int DIM_W     = hbs_pkg::DIM_W;
  localparam int ROW_W     = hbs_pkg::ROW_W;
  localparam int ADDR_W    = hbs_pkg::ADDR_W;
  localparam int COORD_W   = hbs_pkg::COORD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [hbs_pkg::CFG_W-1:0] grid_w_q, grid_h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= hbs_pkg::CFG_W'(256);
      grid_h_q <= hbs_pkg::CFG_W'(256);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hbs_pkg::CFG_GRID_WIDTH:  grid_w_q <= cfg_i.data;
        hbs_pkg::CFG_GRID_HEIGHT: grid_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective dimensions, clamped to the store size
  logic [DIM_W-1:0] w_eff, h_eff;

  assign w_eff = (32'(grid_w_q) > hbs_pkg::MAX_DIM) ? DIM_W'(hbs_pkg::MAX_DIM)
                                                   : DIM_W'(grid_w_q);
  assign h_eff = (32'(grid_h_q) > hbs_pkg::MAX_DIM) ? DIM_W'(hbs_pkg::MAX_DIM)
                                                   : DIM_W'(grid_h_q);

  // ---------------------------------------------------------------------------
  // Request decode: range check, integer/fraction split, +1 neighbour clamp
  // ---------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] inc;
    inc = DIM_W'(idx) + DIM_W'(1);
    return (inc >= dim) ? IDX_W'(dim - DIM_W'(1)) : IDX_W'(inc);
  endfunction

  logic                  x_out, z_out, in_range;
  logic [IDX_W-1:0]      xi_in, zi_in;
  logic [FRAC_BITS-1:0]  fx_in, fz_in;
  logic                  wr_ok;

  assign x_out = req_i.query_x[COORD_W-1] ||
                 (32'(req_i.query_x[COORD_W-2:0]) >= 32'({w_eff, {FRAC_BITS{1'b0}}}));
  assign z_out = req_i.query_z[COORD_W-1] ||
                 (32'(req_i.query_z[COORD_W-2:0]) >= 32'({h_eff, {FRAC_BITS{1'b0}}}));
  assign in_range = !x_out && !z_out;

  assign xi_in = req_i.query_x[FRAC_BITS +: IDX_W];
  assign zi_in = req_i.query_z[FRAC_BITS +: IDX_W];
  assign fx_in = req_i.query_x[FRAC_BITS-1:0];
  assign fz_in = req_i.query_z[FRAC_BITS-1:0];

  assign wr_ok = 32'(req_i.texel_index) < hbs_pkg::STORE_DEPTH;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  hbs_pkg::hbs_state_e    state_d, state_q;
  logic [1:0]             rd_cnt_d, rd_cnt_q;
  logic                   rd_pend_q;
  logic [1:0]             rd_sel_q;

  // sample held for the duration of the lookup
  logic [IDX_W-1:0]       xi_q, zi_q, xn_q, zn_q;
  logic [FRAC_BITS-1:0]   fx_q, fz_q;
  logic [ROW_W-1:0]       row0_q, row1_q;

  logic                   load_sample, load_rows, set_outside, load_quot, out_load;
  logic                   mem_en, mem_we;
  logic [ADDR_W-1:0]      mem_addr, rd_addr;
  logic [hbs_pkg::TEXEL_W-1:0] mem_rdata;
  logic [ROW_W-1:0]       rd_row;
  logic [IDX_W-1:0]       rd_col;

  hbs_pkg::hbs_mac_ctrl_t mac_ctrl;
  logic [hbs_pkg::SUM_W-1:0] mac_sum;
  logic                   mac_done;
  logic                   div_start, div_done;
  logic [hbs_pkg::HEIGHT_W-1:0] div_quot;

  logic [hbs_pkg::HEIGHT_W-1:0] res_height_q;
  logic                   res_outside_q;
  logic                   out_valid_d, out_valid_q;
  logic [hbs_pkg::HEIGHT_W-1:0] out_height_q;
  logic                   out_outside_q;

  // corner order: 0 (xi,zi), 1 (xn,zi), 2 (xi,zn), 3 (xn,zn)
  assign rd_row  = rd_cnt_q[1] ? row1_q : row0_q;
  assign rd_col  = rd_cnt_q[0] ? xn_q : xi_q;
  assign rd_addr = ADDR_W'(rd_row + ROW_W'(rd_col));

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    req_i.ready = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = rd_addr;
    load_sample = 1'b0;
    load_rows   = 1'b0;
    set_outside = 1'b0;
    load_quot   = 1'b0;
    out_load    = 1'b0;
    div_start   = 1'b0;
    mac_ctrl.setup = 1'b0;
    mac_ctrl.take  = rd_pend_q;
    mac_ctrl.sel   = rd_sel_q;

    case (state_q)
      hbs_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.mode == hbs_pkg::MODE_WRITE) begin
            mem_en   = wr_ok;
            mem_we   = 1'b1;
            mem_addr = ADDR_W'(req_i.texel_index);
          end else begin
            load_sample = 1'b1;
            if (in_range) begin
              state_d = hbs_pkg::ST_SETUP;
            end else begin
              set_outside = 1'b1;
              state_d     = hbs_pkg::ST_DONE;
            end
          end
        end
      end
      hbs_pkg::ST_SETUP: begin
        load_rows      = 1'b1;
        mac_ctrl.setup = 1'b1;
        rd_cnt_d       = '0;
        state_d        = hbs_pkg::ST_READ;
      end
      hbs_pkg::ST_READ: begin
        mem_en   = 1'b1;
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd3) begin
          state_d = hbs_pkg::ST_WAIT;
        end
      end
      hbs_pkg::ST_WAIT: begin
        if (mac_done) begin
          div_start = 1'b1;
          state_d   = hbs_pkg::ST_DIV;
        end
      end
      hbs_pkg::ST_DIV: begin
        if (div_done) begin
          load_quot = 1'b1;
          state_d   = hbs_pkg::ST_DONE;
        end
      end
      hbs_pkg::ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = hbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hbs_pkg::ST_IDLE;
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
      rd_sel_q  <= '0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_pend_q <= (state_q == hbs_pkg::ST_READ);
      rd_sel_q  <= rd_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sample) begin
      xi_q <= xi_in;
      zi_q <= zi_in;
      xn_q <= next_idx(xi_in, w_eff);
      zn_q <= next_idx(zi_in, h_eff);
      fx_q <= fx_in;
      fz_q <= fz_in;
    end
    if (load_rows) begin
      row0_q <= ROW_W'(zi_q) * ROW_W'(w_eff);
      row1_q <= ROW_W'(zn_q) * ROW_W'(w_eff);
    end
    if (set_outside) begin
      res_height_q  <= '0;
      res_outside_q <= 1'b1;
    end else if (load_quot) begin
      res_height_q  <= div_quot;
      res_outside_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Heightmap store, multiply-accumulate and divide
  // ---------------------------------------------------------------------------
  hbs_ram #(
    .WIDTH (hbs_pkg::TEXEL_W),
    .DEPTH (hbs_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (req_i.texel_value),
    .rdata_o (mem_rdata)
  );

  hbs_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .fx_i    (fx_q),
    .fz_i    (fz_q),
    .rdata_i (mem_rdata),
    .sum_o   (mac_sum),
    .done_o  (mac_done)
  );

  hbs_div100 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (mac_sum),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_height_q  <= res_height_q;
      out_outside_q <= res_outside_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.height  = out_height_q;
  assign rsp_o.outside = out_outside_q;

endmodule

`default_nettype wire

FILE: dv/heightmap_bilinear_sampler_unit_test.sv
// Self-checking test of the heightmap bilinear sampler: texel loads, samples, grid settings.
`default_nettype none

typedef struct {
  logic                                mode;
  logic [hbs_pkg::TEXEL_IDX_W-1:0]     texel_index;
  logic [hbs_pkg::TEXEL_W-1:0]         texel_value;
  logic signed [hbs_pkg::COORD_W-1:0]  query_x;
  logic signed [hbs_pkg::COORD_W-1:0]  query_z;
} hbs_request_t;

typedef struct {
  logic [hbs_pkg::HEIGHT_W-1:0]  height;
  logic                          outside;
} hbs_height_t;

class height_scoreboard;
  byte unsigned        heights [hbs_pkg::STORE_DEPTH];
  logic [hbs_pkg::CFG_W-1:0] width_reg;
  logic [hbs_pkg::CFG_W-1:0] height_reg;
  hbs_height_t         awaited_heights [$];
  int                  mismatches;
  int                  checked;

  function new();
    width_reg  = 9'd256;
    height_reg = 9'd256;
    mismatches = 0;
    checked    = 0;
  endfunction

  task report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function void write_register(input logic [hbs_pkg::CFG_IDX_W-1:0] idx,
                               input logic [hbs_pkg::CFG_W-1:0] val);
    if (idx == hbs_pkg::CFG_GRID_WIDTH) width_reg = val;
    else if (idx == hbs_pkg::CFG_GRID_HEIGHT) height_reg = val;
  endfunction

  function automatic longint texel_at(input longint col, input longint row, input longint w);
    return longint'(heights[col + row * w]);
  endfunction

  // bilinear blend of the four neighbours, floor(sum / 100) at 16 fraction bits
  function automatic hbs_height_t blend_height(input hbs_request_t r);
    hbs_height_t res;
    longint w, h, x, z, xi, zi, xn, zn, fx, fz, sum;
    w = (width_reg > 256) ? 256 : longint'(width_reg);
    h = (height_reg > 256) ? 256 : longint'(height_reg);
    x = longint'(r.query_x);
    z = longint'(r.query_z);
    res.height  = '0;
    res.outside = 1'b1;
    if (x < 0 || x >= w * 256 || z < 0 || z >= h * 256) return res;
    xi = x >>> 8;
    zi = z >>> 8;
    fx = x & 255;
    fz = z & 255;
    xn = (xi + 1 >= w) ? w - 1 : xi + 1;
    zn = (zi + 1 >= h) ? h - 1 : zi + 1;
    sum = texel_at(xi, zi, w) * (256 - fx) * (256 - fz)
        + texel_at(xn, zi, w) * fx * (256 - fz)
        + texel_at(xi, zn, w) * (256 - fx) * fz
        + texel_at(xn, zn, w) * fx * fz;
    res.height  = hbs_pkg::HEIGHT_W'(sum / 100);
    res.outside = 1'b0;
    return res;
  endfunction

  function void note_request(input hbs_request_t r);
    if (r.mode == hbs_pkg::MODE_WRITE) heights[r.texel_index] = r.texel_value;
    else awaited_heights.push_back(blend_height(r));
  endfunction

  task check_result(input logic [hbs_pkg::HEIGHT_W-1:0] height, input logic outside);
    hbs_height_t exp_h;
    checked++;
    if (awaited_heights.size() == 0) begin
      report_mismatch($sformatf("result height=%0d outside=%0b with none awaited",
                                height, outside));
      return;
    end
    exp_h = awaited_heights.pop_front();
    if (height !== exp_h.height)
      report_mismatch($sformatf("result %0d: height %0d, expected %0d",
                                checked, height, exp_h.height));
    if (outside !== exp_h.outside)
      report_mismatch($sformatf("result %0d: outside %0b, expected %0b",
                                checked, outside, exp_h.outside));
  endtask

  function int awaited();
    return awaited_heights.size();
  endfunction
endclass

module heightmap_bilinear_sampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;   // long enough for an in-grid sample to clear the block
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 53;
  localparam int NUM_PHASES   = 10;

  logic clk_i;
  logic rst_ni;

  hbs_cfg_if cfg_bus ();
  hbs_req_if req_bus ();
  hbs_rsp_if rsp_bus ();

  heightmap_bilinear_sampler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  height_scoreboard sb;

  // Generator-side view: which texels have been loaded and the grid in force
  bit gen_written [hbs_pkg::STORE_DEPTH];
  int gen_w;
  int gen_h;
  int items_sent;
  int gap_pct;
  bit calm;            // final stretch: no idling on either side
  bit long_hold_done;
  int hold_left;
  int cycle_count;

  int phase_w [NUM_PHASES] = '{1, 2, 0, 511, 256, 1, 13, 37, 300, 256};
  int phase_h [NUM_PHASES] = '{1, 3, 7, 300, 1, 256, 0, 19, 5, 256};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends the run if the traffic never drains
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Monitors: every request, result and register write is taken at the edge it
  // handshakes, from the values held just before that edge.
  always @(posedge clk_i) begin
    hbs_request_t seen;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_register(cfg_bus.index, cfg_bus.data);
      if (req_bus.valid && req_bus.ready) begin
        seen.mode        = req_bus.mode;
        seen.texel_index = req_bus.texel_index;
        seen.texel_value = req_bus.texel_value;
        seen.query_x     = req_bus.query_x;
        seen.query_z     = req_bus.query_z;
        sb.note_request(seen);
      end
      if (rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.height, rsp_bus.outside);
    end
  end

  // Result side back-pressure. Short random stalls, plus one long hold-off once a
  // few dozen results are in, so the result register fills and the block has to
  // stall its request side while the sender keeps offering.
  initial begin
    rsp_bus.ready <= 1'b0;
    long_hold_done = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!long_hold_done && sb.checked >= 60) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 4);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Present one request and wait for it to be taken. Valid is left high so a
  // following request goes out back to back.
  task automatic drive_request(input hbs_request_t r);
    req_bus.valid       <= 1'b1;
    req_bus.mode        <= r.mode;
    req_bus.texel_index <= r.texel_index;
    req_bus.texel_value <= r.texel_value;
    req_bus.query_x     <= r.query_x;
    req_bus.query_z     <= r.query_z;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic maybe_pause();
    int n;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 5);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Texel load; query fields carry junk, the block must ignore them
  task automatic put_texel(input int addr, input int val);
    hbs_request_t r;
    r.mode        = hbs_pkg::MODE_WRITE;
    r.texel_index = hbs_pkg::TEXEL_IDX_W'(addr);
    r.texel_value = hbs_pkg::TEXEL_W'(val);
    r.query_x     = hbs_pkg::COORD_W'($urandom);
    r.query_z     = hbs_pkg::COORD_W'($urandom);
    gen_written[addr[15:0]] = 1'b1;
    drive_request(r);
    maybe_pause();
  endtask

  // Sample at (x, z). For an in-grid point, any of the four neighbours not yet
  // loaded is written first, so no sample ever reads an unloaded texel.
  task automatic issue_sample(input int x, input int z);
    hbs_request_t r;
    int xi, zi, xn, zn;
    int corner [4];
    if (x >= 0 && x < gen_w * 256 && z >= 0 && z < gen_h * 256) begin
      xi = x >> 8;
      zi = z >> 8;
      xn = (xi + 1 >= gen_w) ? gen_w - 1 : xi + 1;
      zn = (zi + 1 >= gen_h) ? gen_h - 1 : zi + 1;
      corner[0] = xi + zi * gen_w;
      corner[1] = xn + zi * gen_w;
      corner[2] = xi + zn * gen_w;
      corner[3] = xn + zn * gen_w;
      foreach (corner[k])
        if (!gen_written[corner[k]]) put_texel(corner[k], $urandom_range(0, 255));
    end
    r.mode        = hbs_pkg::MODE_SAMPLE;
    r.texel_index = hbs_pkg::TEXEL_IDX_W'($urandom);
    r.texel_value = hbs_pkg::TEXEL_W'($urandom);
    r.query_x     = hbs_pkg::COORD_W'(x);
    r.query_z     = hbs_pkg::COORD_W'(z);
    drive_request(r);
    maybe_pause();
  endtask

  // Coordinate along an axis of dim texels: mostly in the grid (anywhere, whole texel,
  // last fraction, near the far edge), else the boundary, negatives, or anything.
  function automatic int pick_coord(input int dim);
    int sel;
    int span;
    sel  = $urandom_range(0, 99);
    span = dim * 256;
    if (dim > 0 && sel < 80) begin
      case ($urandom_range(0, 3))
        0: return $urandom_range(0, span - 1);
        1: return $urandom_range(0, dim - 1) * 256;
        2: return $urandom_range(0, dim - 1) * 256 + 255;
        default: return span - 1 - $urandom_range(0, 255);
      endcase
    end
    if (sel < 88) return span;
    if (sel < 94) return -int'($urandom_range(1, 262144));
    return int'($urandom_range(0, 524287)) - 262144;
  endfunction

  task automatic write_register(input logic [hbs_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= hbs_pkg::CFG_W'(val);
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  // Let every awaited result come back, then give any trailing texel load or
  // sample time to clear before the grid is touched.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.awaited() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid(input int w, input int h);
    write_register(hbs_pkg::CFG_GRID_WIDTH, w);
    write_register(hbs_pkg::CFG_GRID_HEIGHT, h);
    cfg_bus.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    gen_w = (w > hbs_pkg::MAX_DIM) ? hbs_pkg::MAX_DIM : w;
    gen_h = (h > hbs_pkg::MAX_DIM) ? hbs_pkg::MAX_DIM : h;
  endtask

  initial begin
    int sel;
    int phase_end;
    sb = new();
    items_sent = 0;
    calm = 1'b0;
    gap_pct = 20;
    gen_w = hbs_pkg::MAX_DIM;
    gen_h = hbs_pkg::MAX_DIM;
    rst_ni              <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.mode        <= hbs_pkg::MODE_WRITE;
    req_bus.texel_index <= '0;
    req_bus.texel_value <= '0;
    req_bus.query_x     <= '0;
    req_bus.query_z     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part on the reset grid of 256 x 256
    put_texel(0, 255);
    put_texel(1, 0);
    put_texel(256, 0);
    put_texel(257, 255);
    put_texel(65279, 1);
    put_texel(65534, 0);
    put_texel(65535, 255);
    issue_sample(0, 0);             // exact texel, full-scale height
    issue_sample(128, 0);           // half way along x
    issue_sample(128, 128);         // centre of the first cell
    issue_sample(255, 255);         // largest fractions
    issue_sample(65535, 65535);     // last texel, both +1 neighbours clamped
    issue_sample(65535, 0);         // clamp on x only
    issue_sample(0, 65535);         // clamp on z only
    issue_sample(65536, 0);         // x on the boundary
    issue_sample(0, 65536);         // z on the boundary
    issue_sample(-1, 0);
    issue_sample(0, -1);
    issue_sample(-262144, 262143);  // coordinate extremes
    issue_sample(262143, -262144);
    drain();

    // Random phases, one grid setting each, from a single texel up to an
    // oversized and a zero-sized register; the last phase runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_grid(phase_w[p], phase_h[p]);
      calm = (p == NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          issue_sample(pick_coord(gen_w), pick_coord(gen_h));
        end else if (sel < 85 || gen_w == 0 || gen_h == 0) begin
          put_texel($urandom_range(0, 65535), $urandom_range(0, 255));
        end else begin
          put_texel($urandom_range(0, gen_w - 1) + $urandom_range(0, gen_h - 1) * gen_w,
                    $urandom_range(0, 255));
        end
      end
      drain();
    end

    if (sb.awaited() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited()));
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: heightmap_bilinear_sampler_unit.f
design/hbs_pkg.sv
design/hbs_cfg_if.sv
design/hbs_req_if.sv
design/hbs_rsp_if.sv
design/hbs_ram.sv
design/hbs_mac.sv
design/hbs_div100.sv
design/heightmap_bilinear_sampler_unit.sv
dv/heightmap_bilinear_sampler_unit_test.sv
